// File: src/baro_median_compensation_unit_defines.svh
// assertion macros shared by the compensation unit modules
`ifndef BARO_MEDIAN_COMPENSATION_UNIT_DEFINES_SVH
`define BARO_MEDIAN_COMPENSATION_UNIT_DEFINES_SVH

// same-cycle implication, clocked on clk, disabled while rst_n is low
`define BMC_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bmc same-cycle check failed");

// next-cycle implication, clocked on clk, disabled while rst_n is low
`define BMC_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bmc next-cycle check failed");

`endif

// File: src/bmc_pkg.sv
// shared types, constants and helpers of the compensation unit
package bmc_pkg;

    localparam int RING_DEPTH = 10;
    localparam int RING_IDX_W = $clog2(RING_DEPTH);
    localparam int CNT_W      = $clog2(RING_DEPTH + 1);
    localparam int MED_IDX    = RING_DEPTH / 2;

    localparam int SAMPLE_W = 24;
    localparam int COEF_W   = 16;
    localparam int NUM_COEF = 6;
    localparam int CFG_IDX_W = 3;

    localparam int MUL_W  = 26;
    localparam int PROD_W = 2 * MUL_W;

    localparam int TEMP_OUT_W  = 15;
    localparam int PRESS_OUT_W = 17;

    localparam logic OP_TEMP  = 1'b0;
    localparam logic OP_PRESS = 1'b1;

    localparam logic [CFG_IDX_W-1:0] REG_PRESS_SENS   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PRESS_OFFSET = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_TC_SENS      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_TC_OFFSET    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REF_TEMP     = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_TEMP_SLOPE   = 3'd5;

    localparam longint TEMP_BASE = 2000;
    localparam longint TEMP_COLD = -1500;
    localparam longint TEMP_MIN  = -4000;
    localparam longint TEMP_MAX  = 8500;
    localparam longint PRESS_MIN = 0;
    localparam longint PRESS_MAX = 120000;

    typedef struct packed {
        logic                go;
        logic                op;
        logic [SAMPLE_W-1:0] sample;
    } med_req_t;

    typedef struct packed {
        logic                done;
        logic [SAMPLE_W-1:0] press_med;
        logic [SAMPLE_W-1:0] temp_med;
    } med_rsp_t;

    // arithmetic right shift that rounds toward zero
    function automatic logic signed [63:0] trunc_shr(input logic signed [63:0] x,
                                                     input logic [5:0] k);
        logic signed [63:0] mag;
        begin
            mag = (x < 0) ? -x : x;
            mag = mag >>> k;
            return (x < 0) ? -mag : mag;
        end
    endfunction

endpackage

// File: src/bmc_mult.sv
// shared signed multiplier with registered product
module bmc_mult
    import bmc_pkg::*;
(
    input  logic                     clk,
    input  logic signed [MUL_W-1:0]  a,
    input  logic signed [MUL_W-1:0]  b,
    output logic signed [PROD_W-1:0] p
);

    logic signed [PROD_W-1:0] p_reg;
    logic signed [PROD_W-1:0] p_next;

    assign p_next = a * b;

    always_ff @(posedge clk)
    begin
        p_reg <= p_next;
    end

    assign p = p_reg;

endmodule

// File: src/bmc_ring_median.sv
// sample rings and rank-search median, one candidate per cycle
module bmc_ring_median
    import bmc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  med_req_t med_req,
    output med_rsp_t med_rsp
);

`include "baro_median_compensation_unit_defines.svh"

    logic [SAMPLE_W-1:0]   press_ring_reg [RING_DEPTH];
    logic [SAMPLE_W-1:0]   temp_ring_reg  [RING_DEPTH];
    logic [RING_IDX_W-1:0] press_slot_reg;
    logic [RING_IDX_W-1:0] temp_slot_reg;
    logic [RING_IDX_W-1:0] cand_reg;
    logic [RING_IDX_W-1:0] cand_next;
    logic                  sel_reg;
    logic                  busy_reg;
    logic                  done_reg;
    logic [SAMPLE_W-1:0]   press_med_reg;
    logic [SAMPLE_W-1:0]   temp_med_reg;

    logic [SAMPLE_W-1:0] cand_val;
    logic [SAMPLE_W-1:0] cmp_val [RING_DEPTH];
    logic [CNT_W-1:0]    lt_cnt;
    logic [CNT_W-1:0]    le_cnt;
    logic                found;

    localparam logic [RING_IDX_W-1:0] LAST_SLOT = RING_IDX_W'(RING_DEPTH - 1);

    always_comb
    begin
        for (int j = 0; j < RING_DEPTH; j++)
        begin
            cmp_val[j] = sel_reg ? press_ring_reg[j] : temp_ring_reg[j];
        end
    end

    assign cand_val = cmp_val[cand_reg];

    // rank of the candidate against every entry of the ring
    always_comb
    begin
        lt_cnt = '0;
        le_cnt = '0;
        for (int j = 0; j < RING_DEPTH; j++)
        begin
            lt_cnt = lt_cnt + CNT_W'(cmp_val[j] <  cand_val);
            le_cnt = le_cnt + CNT_W'(cmp_val[j] <= cand_val);
        end
    end

    assign found = (lt_cnt <= CNT_W'(MED_IDX)) && (le_cnt > CNT_W'(MED_IDX));
    assign cand_next = cand_reg + RING_IDX_W'(1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int j = 0; j < RING_DEPTH; j++)
            begin
                press_ring_reg[j] <= '0;
                temp_ring_reg[j]  <= '0;
            end
            press_slot_reg <= '0;
            temp_slot_reg  <= '0;
            cand_reg       <= '0;
            sel_reg        <= OP_TEMP;
            busy_reg       <= 1'b0;
            done_reg       <= 1'b0;
            press_med_reg  <= '0;
            temp_med_reg   <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (med_req.go)
            begin
                if (med_req.op == OP_PRESS)
                begin
                    press_ring_reg[press_slot_reg] <= med_req.sample;
                    press_slot_reg <= (press_slot_reg == LAST_SLOT) ? '0
                                                                    : press_slot_reg + 1'b1;
                end
                else
                begin
                    temp_ring_reg[temp_slot_reg] <= med_req.sample;
                    temp_slot_reg <= (temp_slot_reg == LAST_SLOT) ? '0
                                                                  : temp_slot_reg + 1'b1;
                end
                sel_reg  <= med_req.op;
                cand_reg <= '0;
                busy_reg <= 1'b1;
            end
            else if (busy_reg)
            begin
                if (found)
                begin
                    if (sel_reg == OP_PRESS)
                    begin
                        press_med_reg <= cand_val;
                    end
                    else
                    begin
                        temp_med_reg <= cand_val;
                    end
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
                else
                begin
                    cand_reg <= cand_next;
                end
            end
        end
    end

    assign med_rsp.done      = done_reg;
    assign med_rsp.press_med = press_med_reg;
    assign med_rsp.temp_med  = temp_med_reg;

    `BMC_ASSERT_IMP(a_go_when_free, med_req.go, !busy_reg)
    `BMC_ASSERT_IMP(a_found_by_last, busy_reg && (cand_reg == LAST_SLOT), found)
    `BMC_ASSERT_IMP(a_done_not_busy, done_reg, !busy_reg)

endmodule

// File: src/baro_median_compensation_unit.sv
// top level: median-filtered barometric temperature and pressure compensation
// path of an accepted beat: the rank search, a handoff, then 14 sequencer steps until its result
//   beat is valid, with S_P5 holding while the previous result beat is not yet taken
// one beat at a time: s_tready is low until the result is registered
// the single shared 26x26 multiplier and the one-candidate-per-cycle median search set the pace
// reset: rings, write slots, medians and coefficients clear to zero, no output pending
module baro_median_compensation_unit
    import bmc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    // input beat
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [23:0]          s_tdata,   // [23:0] raw_sample
    input  logic                 s_tuser,   // [0] op
    // result beat
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [31:0]          m_tdata,   // [14:0] temperature_centideg, [31:15] pressure_centimbar
    output logic                 m_tuser,   // [0] low_temp_correction
    // coefficient writes
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [COEF_W-1:0]    cfg_data
);

`include "baro_median_compensation_unit_defines.svh"

    // sequencer codes
    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_MED  = 5'd1;
    localparam logic [4:0] S_DT   = 5'd2;
    localparam logic [4:0] S_M1   = 5'd3;
    localparam logic [4:0] S_M2   = 5'd4;
    localparam logic [4:0] S_M3   = 5'd5;
    localparam logic [4:0] S_M4   = 5'd6;
    localparam logic [4:0] S_M5   = 5'd7;
    localparam logic [4:0] S_M6   = 5'd8;
    localparam logic [4:0] S_M7   = 5'd9;
    localparam logic [4:0] S_FIN  = 5'd10;
    localparam logic [4:0] S_P1   = 5'd11;
    localparam logic [4:0] S_P2   = 5'd12;
    localparam logic [4:0] S_P3   = 5'd13;
    localparam logic [4:0] S_P4   = 5'd14;
    localparam logic [4:0] S_P5   = 5'd15;

    localparam int DT_W  = 26;  // d2 - c5*256
    localparam int T_W   = 20;  // temperature working value
    localparam int OFF_W = 42;  // offset and sensitivity terms
    localparam int PQ_W  = 44;

    logic [4:0] state_reg;
    logic [4:0] state_next;

    // coefficient bank
    logic [COEF_W-1:0] c1_reg, c2_reg, c3_reg, c4_reg, c5_reg, c6_reg;

    // datapath registers
    logic signed [DT_W-1:0]  dt_reg;
    logic signed [T_W-1:0]   t_reg;
    logic signed [T_W-1:0]   t2_reg;
    logic signed [OFF_W-1:0] off_reg;
    logic signed [OFF_W-1:0] sens_reg;
    logic signed [OFF_W-1:0] off2_reg;
    logic signed [OFF_W-1:0] sens2_reg;
    logic signed [63:0]      acc_reg;
    logic signed [PQ_W-1:0]  pq_reg;
    logic                    low_reg;
    logic                    cold_reg;

    // result register
    logic                          m_tvalid_reg;
    logic signed [TEMP_OUT_W-1:0]  temp_out_reg;
    logic [PRESS_OUT_W-1:0]        press_out_reg;
    logic                          low_out_reg;

    med_req_t med_req;
    med_rsp_t med_rsp;

    logic signed [MUL_W-1:0]  mul_a;
    logic signed [MUL_W-1:0]  mul_b;
    logic signed [PROD_W-1:0] mul_p;
    logic signed [63:0]       prod64;
    logic signed [63:0]       dd64;
    logic signed [63:0]       e64;
    logic signed [63:0]       pres64;
    logic signed [63:0]       temp64;
    logic                     out_free;

    assign s_tready  = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign med_req.go     = s_tvalid && s_tready;
    assign med_req.op     = s_tuser;
    assign med_req.sample = s_tdata;

    bmc_ring_median u_median
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .med_req (med_req),
        .med_rsp (med_rsp)
    );

    bmc_mult u_mult
    (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    assign prod64 = 64'(mul_p);
    assign dd64   = 64'(t_reg) - TEMP_BASE;
    assign e64    = 64'(t_reg) - TEMP_COLD;
    assign pres64 = trunc_shr(64'(pq_reg), 6'd15);
    assign temp64 = 64'(t_reg);

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_M1:
            begin
                mul_a = dt_reg;
                mul_b = signed'(MUL_W'(c6_reg));
            end
            S_M2:
            begin
                mul_a = dt_reg;
                mul_b = signed'(MUL_W'(c4_reg));
            end
            S_M3:
            begin
                mul_a = dt_reg;
                mul_b = signed'(MUL_W'(c3_reg));
            end
            S_M4:
            begin
                mul_a = dt_reg;
                mul_b = dt_reg;
            end
            S_M5:
            begin
                mul_a = MUL_W'(dd64);
                mul_b = MUL_W'(dd64);
            end
            S_M6:
            begin
                mul_a = MUL_W'(e64);
                mul_b = MUL_W'(e64);
            end
            S_P1:
            begin
                // low part of sens, unsigned
                mul_a = signed'(MUL_W'(med_rsp.press_med));
                mul_b = signed'(MUL_W'(sens_reg[20:0]));
            end
            S_P2:
            begin
                // high part of sens, signed
                mul_a = signed'(MUL_W'(med_rsp.press_med));
                mul_b = MUL_W'(sens_reg >>> 21);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: state_next = med_req.go ? S_MED : S_IDLE;
            S_MED:  state_next = med_rsp.done ? S_DT : S_MED;
            S_DT:   state_next = S_M1;
            S_M1:   state_next = S_M2;
            S_M2:   state_next = S_M3;
            S_M3:   state_next = S_M4;
            S_M4:   state_next = S_M5;
            S_M5:   state_next = S_M6;
            S_M6:   state_next = S_M7;
            S_M7:   state_next = S_FIN;
            S_FIN:  state_next = S_P1;
            S_P1:   state_next = S_P2;
            S_P2:   state_next = S_P3;
            S_P3:   state_next = S_P4;
            S_P4:   state_next = S_P5;
            S_P5:   state_next = out_free ? S_IDLE : S_P5;
            default: state_next = S_IDLE;
        endcase
    end

    // control and coefficient registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            m_tvalid_reg <= 1'b0;
            c1_reg       <= '0;
            c2_reg       <= '0;
            c3_reg       <= '0;
            c4_reg       <= '0;
            c5_reg       <= '0;
            c6_reg       <= '0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_P5 && out_free)
            begin
                m_tvalid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                m_tvalid_reg <= 1'b0;
            end
            if (cfg_valid && cfg_ready)
            begin
                unique case (cfg_index)
                    REG_PRESS_SENS:   c1_reg <= cfg_data;
                    REG_PRESS_OFFSET: c2_reg <= cfg_data;
                    REG_TC_SENS:      c3_reg <= cfg_data;
                    REG_TC_OFFSET:    c4_reg <= cfg_data;
                    REG_REF_TEMP:     c5_reg <= cfg_data;
                    REG_TEMP_SLOPE:   c6_reg <= cfg_data;
                    default:          ;
                endcase
            end
        end
    end

    // compensation datapath, one step per sequencer state
    always_ff @(posedge clk)
    begin
        case (state_reg)
            S_DT:
            begin
                dt_reg <= signed'(DT_W'({2'b00, med_rsp.temp_med}))
                        - signed'(DT_W'({c5_reg, 8'h00}));
            end
            S_M2:
            begin
                t_reg <= T_W'(TEMP_BASE + trunc_shr(prod64, 6'd23));
            end
            S_M3:
            begin
                off_reg <= OFF_W'((64'(c2_reg) <<< 16) + trunc_shr(prod64, 6'd7));
            end
            S_M4:
            begin
                sens_reg <= OFF_W'((64'(c1_reg) <<< 15) + trunc_shr(prod64, 6'd8));
                low_reg  <= (temp64 < TEMP_BASE);
                cold_reg <= (temp64 < TEMP_COLD);
            end
            S_M5:
            begin
                // dt squared is never negative
                t2_reg <= T_W'(prod64 >>> 31);
            end
            S_M6:
            begin
                off2_reg  <= OFF_W'((prod64 * 5) >>> 1);
                sens2_reg <= OFF_W'((prod64 * 5) >>> 2);
            end
            S_M7:
            begin
                // extra terms below the cold threshold
                if (cold_reg)
                begin
                    off2_reg  <= OFF_W'(64'(off2_reg) + prod64 * 7);
                    sens2_reg <= OFF_W'(64'(sens2_reg) + ((prod64 * 11) >>> 1));
                end
            end
            S_FIN:
            begin
                if (low_reg)
                begin
                    t_reg    <= t_reg - t2_reg;
                    off_reg  <= off_reg - off2_reg;
                    sens_reg <= sens_reg - sens2_reg;
                end
            end
            S_P2:
            begin
                acc_reg <= prod64;
            end
            S_P3:
            begin
                acc_reg <= acc_reg + (prod64 <<< 21);
            end
            S_P4:
            begin
                pq_reg <= PQ_W'(trunc_shr(acc_reg, 6'd21) - 64'(off_reg));
            end
            S_P5:
            begin
                if (out_free)
                begin
                    // saturate to the output ranges
                    if (temp64 < TEMP_MIN)
                    begin
                        temp_out_reg <= TEMP_OUT_W'(TEMP_MIN);
                    end
                    else if (temp64 > TEMP_MAX)
                    begin
                        temp_out_reg <= TEMP_OUT_W'(TEMP_MAX);
                    end
                    else
                    begin
                        temp_out_reg <= TEMP_OUT_W'(temp64);
                    end
                    if (pres64 < PRESS_MIN)
                    begin
                        press_out_reg <= PRESS_OUT_W'(PRESS_MIN);
                    end
                    else if (pres64 > PRESS_MAX)
                    begin
                        press_out_reg <= PRESS_OUT_W'(PRESS_MAX);
                    end
                    else
                    begin
                        press_out_reg <= PRESS_OUT_W'(pres64);
                    end
                    low_out_reg <= low_reg;
                end
            end
            default:
            begin
            end
        endcase
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {press_out_reg, temp_out_reg};
    assign m_tuser  = low_out_reg;

    `BMC_ASSERT_NXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    `BMC_ASSERT_IMP(a_done_in_med, med_rsp.done, state_reg == S_MED)
    `BMC_ASSERT_IMP(a_low_flag_matches, m_tvalid_reg, low_out_reg == (temp_out_reg < 15'sd2000))

endmodule

// File: verif/baro_median_compensation_unit_test.sv
// testbench for the median-filtered barometric compensation unit
`timescale 1ns / 1ps

module baro_median_compensation_unit_test;
    import bmc_pkg::*;

    logic                 clk;
    logic                 rst_n;
    logic                 s_tvalid;
    logic                 s_tready;
    logic [23:0]          s_tdata;   // [23:0] raw_sample
    logic                 s_tuser;   // [0] op
    logic                 m_tvalid;
    logic                 m_tready;
    logic [31:0]          m_tdata;   // [14:0] temperature_centideg, [31:15] pressure_centimbar
    logic                 m_tuser;   // [0] low_temp_correction
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COEF_W-1:0]    cfg_data;

    // one expected result beat
    typedef struct {
        logic signed [14:0] temp;
        logic [16:0]        press;
        logic               low;
    } baro_result_t;

    baro_result_t expected_results[$];

    // shadow of the block's rings and coefficients
    logic [23:0] press_hist[RING_DEPTH];
    logic [23:0] temp_hist[RING_DEPTH];
    int          press_slot;
    int          temp_slot;
    logic [15:0] coef_shadow[NUM_COEF];

    int     error_count;
    longint cycle_count;
    int     idle_pct_in;
    int     idle_pct_out;
    bit     hold_sink;

    baro_median_compensation_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial clk = 1'b0;
    always #1 clk = ~clk;

    task automatic report_mismatch(input string what, input longint got, input longint want);
        begin
            $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want,
                     cycle_count);
            error_count++;
        end
    endtask

    // upper-middle entry of the sorted ring
    function automatic longint ring_mid(input logic [23:0] ring[RING_DEPTH]);
        logic [23:0] buf_s[RING_DEPTH];
        logic [23:0] v;
        int j;
        begin
            buf_s = ring;
            for (int i = 1; i < RING_DEPTH; i++)
            begin
                v = buf_s[i];
                j = i - 1;
                while (j >= 0 && buf_s[j] > v)
                begin
                    buf_s[j + 1] = buf_s[j];
                    j--;
                end
                buf_s[j + 1] = v;
            end
            return longint'(buf_s[MED_IDX]);
        end
    endfunction

    // update rings and work out the compensated result for one sample
    function automatic baro_result_t compensate(input logic op, input logic [23:0] sample);
        baro_result_t r;
        longint d1, d2, dt, t, off, sens, p, t2, dd, off2, sens2, e;
        longint c1, c2, c3, c4, c5, c6;
        bit low;
        begin
            if (op == OP_PRESS)
            begin
                press_hist[press_slot] = sample;
                press_slot = (press_slot + 1) % RING_DEPTH;
            end
            else
            begin
                temp_hist[temp_slot] = sample;
                temp_slot = (temp_slot + 1) % RING_DEPTH;
            end
            c1 = coef_shadow[0]; c2 = coef_shadow[1]; c3 = coef_shadow[2];
            c4 = coef_shadow[3]; c5 = coef_shadow[4]; c6 = coef_shadow[5];
            d1 = ring_mid(press_hist);
            d2 = ring_mid(temp_hist);
            dt = d2 - c5 * 256;
            t = TEMP_BASE + (dt * c6) / 8388608;
            off = c2 * 65536 + (c4 * dt) / 128;
            sens = c1 * 32768 + (c3 * dt) / 256;
            low = t < TEMP_BASE;
            if (low)
            begin
                t2 = (dt * dt) / 64'sd2147483648;
                dd = t - TEMP_BASE;
                off2 = (5 * dd * dd) / 2;
                sens2 = (5 * dd * dd) / 4;
                if (t < TEMP_COLD)
                begin
                    e = t - TEMP_COLD;
                    off2 += 7 * e * e;
                    sens2 += (11 * e * e) / 2;
                end
                t -= t2;
                off -= off2;
                sens -= sens2;
            end
            p = ((d1 * sens) / 2097152 - off) / 32768;
            if (t < TEMP_MIN) t = TEMP_MIN;
            if (t > TEMP_MAX) t = TEMP_MAX;
            if (p < PRESS_MIN) p = PRESS_MIN;
            if (p > PRESS_MAX) p = PRESS_MAX;
            r.temp = t[14:0];
            r.press = p[16:0];
            r.low = low;
            return r;
        end
    endfunction

    // send one sample beat, with random idle before it
    task automatic send_sample(input logic op, input logic [23:0] sample);
        begin
            while ($urandom_range(99) < idle_pct_in)
                @(posedge clk);
            s_tvalid <= 1'b1;
            s_tuser  <= op;
            s_tdata  <= sample;
            @(posedge clk);
            while (!s_tready)
                @(posedge clk);
            // accepted at this edge
            expected_results.push_back(compensate(op, sample));
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
    endtask

    task automatic write_coef(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] val);
        begin
            cfg_valid <= 1'b1;
            cfg_index <= idx;
            cfg_data  <= val;
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
            if (idx < NUM_COEF)
                coef_shadow[idx] = val;
            cfg_valid <= 1'b0;
            @(posedge clk);
        end
    endtask

    // block idle: no expectations left, then wait out the latency
    task automatic drain;
        begin
            while (expected_results.size() != 0)
                @(posedge clk);
            repeat (30) @(posedge clk);
        end
    endtask

    task automatic load_coefs(input logic [15:0] c[NUM_COEF]);
        begin
            drain();
            write_coef(REG_PRESS_SENS, c[0]);
            write_coef(REG_PRESS_OFFSET, c[1]);
            write_coef(REG_TC_SENS, c[2]);
            write_coef(REG_TC_OFFSET, c[3]);
            write_coef(REG_REF_TEMP, c[4]);
            write_coef(REG_TEMP_SLOPE, c[5]);
        end
    endtask

    // typical calibration words of such a sensor
    task automatic test_typical_coefs;
        logic [15:0] c[NUM_COEF];
        begin
            c = '{16'd40127, 16'd36924, 16'd23317, 16'd23282, 16'd33464, 16'd28312};
            load_coefs(c);
            // zero and all-ones raw samples, then warm and cold temperatures
            send_sample(OP_TEMP, 24'h000000);
            send_sample(OP_PRESS, 24'hFFFFFF);
            for (int i = 0; i < 6; i++)
            begin
                send_sample(OP_TEMP, 24'd8569150);
                send_sample(OP_PRESS, 24'd9085466);
            end
            for (int i = 0; i < 6; i++)
                send_sample(OP_TEMP, 24'd5000000);
            for (int i = 0; i < 6; i++)
                send_sample(OP_TEMP, 24'hFFFFFF);
        end
    endtask

    // out-of-range register index is ignored, then the extremes
    task automatic test_coef_extremes;
        logic [15:0] c[NUM_COEF];
        begin
            drain();
            write_coef(3'd6, 16'hFFFF);
            write_coef(3'd7, 16'h1234);
            c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
            load_coefs(c);
            send_sample(OP_PRESS, 24'hFFFFFF);
            send_sample(OP_TEMP, 24'h000000);
            c = '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000};
            load_coefs(c);
            send_sample(OP_PRESS, 24'h800000);
            send_sample(OP_TEMP, 24'h7FFFFF);
        end
    endtask

    task automatic random_samples(input int count);
        logic op;
        logic [23:0] s;
        begin
            for (int i = 0; i < count; i++)
            begin
                op = 1'($urandom_range(1));
                case ($urandom_range(3))
                    0: s = 24'($urandom);
                    1: s = 24'($urandom_range(16777215, 16000000));
                    2: s = 24'($urandom_range(100000));
                    default: s = (op == OP_TEMP) ? 24'(8569150 + $urandom_range(400000) - 200000)
                                                 : 24'(9085466 + $urandom_range(800000) - 400000);
                endcase
                send_sample(op, s);
            end
        end
    endtask

    // several random calibration sets, each with random samples
    task automatic test_random_phases;
        logic [15:0] c[NUM_COEF];
        begin
            for (int ph = 0; ph < 6; ph++)
            begin
                for (int k = 0; k < NUM_COEF; k++)
                    c[k] = (ph % 2) ? 16'($urandom) : 16'(20000 + $urandom_range(25000));
                load_coefs(c);
                random_samples(ph == 2 ? 150 : 330);
            end
        end
    endtask

    // receiver holds off while the sender keeps offering beats
    task automatic test_backpressure;
        begin
            hold_sink = 1'b1;
            fork
                random_samples(8);
                begin
                    repeat (300) @(posedge clk);
                    hold_sink = 1'b0;
                end
            join
            // a stretch with no idling on either side
            idle_pct_in = 0;
            idle_pct_out = 0;
            random_samples(150);
            idle_pct_in = 28;
            idle_pct_out = 28;
        end
    endtask

    // result sink: random stalls, compares each beat with the oldest expectation
    always @(posedge clk)
    begin
        baro_result_t want;
        if (rst_n)
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_results.size() == 0)
                begin
                    $display("unexpected result beat at cycle %0d", cycle_count);
                    error_count++;
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (m_tdata[14:0] !== want.temp)
                        report_mismatch("temperature", $signed(m_tdata[14:0]), want.temp);
                    if (m_tdata[31:15] !== want.press)
                        report_mismatch("pressure", m_tdata[31:15], want.press);
                    if (m_tuser !== want.low)
                        report_mismatch("low_temp_correction", m_tuser, want.low);
                end
            end
            m_tready <= !hold_sink && ($urandom_range(99) >= idle_pct_out);
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 400000)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    initial
    begin
        error_count = 0;
        cycle_count = 0;
        idle_pct_in = 28;
        idle_pct_out = 28;
        hold_sink = 1'b0;
        press_slot = 0;
        temp_slot = 0;
        for (int i = 0; i < RING_DEPTH; i++)
        begin
            press_hist[i] = '0;
            temp_hist[i] = '0;
        end
        for (int i = 0; i < NUM_COEF; i++)
            coef_shadow[i] = '0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = 1'b0;
        m_tready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset coefficients are all zero
        send_sample(OP_PRESS, 24'h123456);
        test_typical_coefs();
        test_coef_extremes();
        test_backpressure();
        test_random_phases();

        drain();
        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/bmc_pkg.sv
src/bmc_mult.sv
src/bmc_ring_median.sv
src/baro_median_compensation_unit.sv
verif/baro_median_compensation_unit_test.sv
